FILE: hw/rtl/ccc_pkg.sv
// Shared types, codes and helpers for the color calibration and correction block.
`default_nettype none
package ccc_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int CHAN_W          = 16;
    localparam int RATIO_W         = 32;
    localparam int DIV_STEPS       = 32;
    localparam logic [RATIO_W-1:0] Q_ONE = 32'h0001_0000;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_CONV = 1'b1;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_LOADED = 2'd1,
        STAT_UNCAL  = 2'd2,
        STAT_ZERO   = 2'd3
    } status_t;

    typedef struct packed {
        logic [CHAN_W-1:0] clear;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } sample_t;

    typedef struct packed {
        logic [RATIO_W-1:0] blue;
        logic [RATIO_W-1:0] green;
        logic [RATIO_W-1:0] red;
    } ratio_t;

    typedef struct packed {
        logic               start;
        logic [31:0]        dividend;
        logic [CHAN_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } div_rsp_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SORT_RI,
        S_SORT_V,
        S_SORT_RJ,
        S_SORT_CMP,
        S_REF_RD,
        S_REF_W,
        S_CAL_RD,
        S_CAL_S,
        S_CAL_DIV,
        S_CAL_WAIT,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_RAT_RD,
        S_RAT_W,
        S_MUL,
        S_CORR,
        S_CORR_WAIT
    } state_t;

    // Pick one color channel (0 red, 1 green, 2 blue) of a sample.
    function automatic logic [CHAN_W-1:0] chan_of(sample_t s, logic [1:0] ch);
        logic [CHAN_W-1:0] v;
        unique case (ch)
            2'd0:    v = s.red;
            2'd1:    v = s.green;
            default: v = s.blue;
        endcase
        return v;
    endfunction

    function automatic logic [RATIO_W-1:0] ratio_of(ratio_t r, logic [1:0] ch);
        logic [RATIO_W-1:0] v;
        unique case (ch)
            2'd0:    v = r.red;
            2'd1:    v = r.green;
            default: v = r.blue;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/ccc_if.sv
// Handshake channels for samples and measurements in, corrected colors out.
`default_nettype none
interface ccc_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [15:0] in_red;
    logic [15:0] in_green;
    logic [15:0] in_blue;
    logic [15:0] in_clear;
    logic        last;
    modport source (output valid, cmd, in_red, in_green, in_blue, in_clear, last,
                    input ready);
    modport sink   (input valid, cmd, in_red, in_green, in_blue, in_clear, last,
                    output ready);
endinterface

interface ccc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [1:0] status;
    modport source (output valid, out_red, out_green, out_blue, status, input ready);
    modport sink   (input valid, out_red, out_green, out_blue, status, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/ccc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ccc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

FILE: hw/rtl/ccc_div.sv
// Restoring divider, 32-bit dividend by 16-bit divisor, one quotient bit per cycle.
`default_nettype none
module ccc_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ccc_pkg::div_req_t req,
    output ccc_pkg::div_rsp_t      rsp
);
    import ccc_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS);

    logic [31:0]       quo_reg, quo_next;
    logic [CHAN_W-1:0] rem_reg, rem_next;
    logic [CHAN_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CHAN_W:0]   shifted;
    logic [CHAN_W:0]   diff;

    // A zero divisor yields all ones, which is the ratio saturation value.
    assign shifted = {rem_reg, quo_reg[31]};
    assign diff    = shifted - {1'b0, den_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            quo_next  = req.dividend;
            rem_next  = '0;
            den_next  = req.divisor;
            cnt_next  = CNT_W'(DIV_STEPS - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, den_reg})
            begin
                rem_next = diff[CHAN_W-1:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[CHAN_W-1:0];
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;
endmodule
`default_nettype wire

FILE: hw/rtl/color_calibration_correct_top.sv
// Top level of the color calibration and correction block.
//
//  channel | dir | handshake     | payload
//  --------+-----+---------------+------------------------------------------------
//  din     | in  | valid / ready | cmd, in_red, in_green, in_blue, in_clear, last
//  dout    | out | valid / ready | out_red, out_green, out_blue, status
//
// One item is worked at a time; din.ready is high only when the sequencer is idle
// and no result waits on dout. A closing load runs an insertion sort in the sample
// RAM, then divides the reference row by each further row for the ratios; a convert
// searches the table, then divides once per channel with a nonzero reference value
// on the shared 32-step divider. No clearing pass runs after reset. A stalled dout
// holds its result and blocks the next item.
`default_nettype none
module color_calibration_correct_top #(
    parameter int TABLE_DEPTH = ccc_pkg::TABLE_DEPTH_DEF
) (
    input wire logic clk,
    input wire logic rst_n,
    ccc_in_if.sink   din,
    ccc_out_if.source dout
);
    import ccc_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    state_t            state_reg, state_next;
    logic [CW-1:0]     cnt_reg, cnt_next;     // samples held in the table
    logic              cal_reg, cal_next;     // table sorted and ratios valid
    logic [CW-1:0]     i_reg, i_next;
    logic [CW-1:0]     j_reg, j_next;
    logic [1:0]        ch_reg, ch_next;
    sample_t           req_reg, req_next;     // item under work
    sample_t           v_reg, v_next;         // sort key / divisor row
    sample_t           ref_reg, ref_next;     // white reference row
    logic [RATIO_W-1:0] q0_reg, q0_next, q1_reg, q1_next;
    ratio_t            rat_reg, rat_next;
    logic [CHAN_W-1:0] p_reg, p_next;
    logic [7:0]        r_reg, r_next, g_reg, g_next, b_reg, b_next;
    logic [1:0]        stat_reg, stat_next;
    logic              ov_reg, ov_next;

    logic              t_we;
    logic [CW-1:0]     t_waddr, t_raddr;
    sample_t           t_wdata, t_rdata;
    logic              r_we;
    logic [CW-1:0]     r_waddr, r_raddr;
    ratio_t            r_wdata, r_rdata;
    div_req_t          dreq;
    div_rsp_t          drsp;

    logic              in_acc;
    sample_t           in_smp;
    logic [CW-1:0]     cnt_eff, cnt_new;
    logic [47:0]       prod;
    logic [7:0]        res;
    logic [CHAN_W-1:0] ref_ch;

    assign in_acc = din.valid && din.ready;
    assign in_smp = '{clear: din.in_clear, blue: din.in_blue,
                      green: din.in_green, red: din.in_red};
    assign ref_ch = chan_of(ref_reg, ch_reg);
    assign prod   = {32'd0, chan_of(req_reg, ch_reg)} * {16'd0, ratio_of(rat_reg, ch_reg)};

    ccc_ram #(.WIDTH($bits(sample_t)), .DEPTH(TABLE_DEPTH)) u_table (
        .clk   (clk),
        .we    (t_we),
        .waddr (t_waddr[AW-1:0]),
        .wdata (t_wdata),
        .raddr (t_raddr[AW-1:0]),
        .rdata (t_rdata)
    );

    ccc_ram #(.WIDTH($bits(ratio_t)), .DEPTH(TABLE_DEPTH)) u_ratio (
        .clk   (clk),
        .we    (r_we),
        .waddr (r_waddr[AW-1:0]),
        .wdata (r_wdata),
        .raddr (r_raddr[AW-1:0]),
        .rdata (r_rdata)
    );

    ccc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cal_next   = cal_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        ch_next    = ch_reg;
        req_next   = req_reg;
        v_next     = v_reg;
        ref_next   = ref_reg;
        q0_next    = q0_reg;
        q1_next    = q1_reg;
        rat_next   = rat_reg;
        p_next     = p_reg;
        r_next     = r_reg;
        g_next     = g_reg;
        b_next     = b_reg;
        stat_next  = stat_reg;
        ov_next    = ov_reg;
        t_we       = 1'b0;
        t_waddr    = j_reg;
        t_wdata    = v_reg;
        t_raddr    = i_reg;
        r_we       = 1'b0;
        r_waddr    = i_reg;
        r_wdata    = '{blue: Q_ONE, green: Q_ONE, red: Q_ONE};
        r_raddr    = i_reg;
        dreq       = '{start: 1'b0, dividend: {ref_ch, 16'd0}, divisor: chan_of(v_reg, ch_reg)};
        cnt_eff    = cal_reg ? '0 : cnt_reg;
        cnt_new    = cnt_eff;
        res        = '0;

        // Drop the result once it is taken.
        if (dout.valid && dout.ready)
        begin
            ov_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    req_next = in_smp;
                    r_next   = '0;
                    g_next   = '0;
                    b_next   = '0;
                    if (din.cmd == CMD_LOAD)
                    begin
                        cal_next = 1'b0;
                        if (cnt_eff < CW'(TABLE_DEPTH))
                        begin
                            t_we    = 1'b1;
                            t_waddr = cnt_eff;
                            t_wdata = in_smp;
                            cnt_new = cnt_eff + 1'b1;
                        end
                        cnt_next  = cnt_new;
                        stat_next = STAT_LOADED;
                        ov_next   = 1'b1;
                        if (din.last)
                        begin
                            if (cnt_new < CW'(2))
                            begin
                                cnt_next  = '0;
                                stat_next = STAT_UNCAL;
                            end
                            else
                            begin
                                ov_next    = 1'b0;
                                i_next     = CW'(1);
                                state_next = S_SORT_RI;
                            end
                        end
                    end
                    else if (!cal_reg)
                    begin
                        stat_next = STAT_UNCAL;
                        ov_next   = 1'b1;
                    end
                    else if (din.in_clear == '0)
                    begin
                        stat_next = STAT_ZERO;
                        ov_next   = 1'b1;
                    end
                    else
                    begin
                        i_next     = cnt_reg - 1'b1;
                        state_next = S_SRCH_RD;
                    end
                end
            end

            // Insertion sort by clear, descending, in the sample RAM.
            S_SORT_RI:
            begin
                t_raddr    = i_reg;
                state_next = S_SORT_V;
            end
            S_SORT_V:
            begin
                v_next     = t_rdata;
                j_next     = i_reg;
                state_next = S_SORT_RJ;
            end
            S_SORT_RJ:
            begin
                if (j_reg == '0)
                begin
                    t_we    = 1'b1;
                    t_waddr = j_reg;
                    t_wdata = v_reg;
                    i_next  = i_reg + 1'b1;
                    state_next = (i_reg + 1'b1 >= cnt_reg) ? S_REF_RD : S_SORT_RI;
                end
                else
                begin
                    t_raddr    = j_reg - 1'b1;
                    state_next = S_SORT_CMP;
                end
            end
            S_SORT_CMP:
            begin
                t_we    = 1'b1;
                t_waddr = j_reg;
                if (t_rdata.clear < v_reg.clear)
                begin
                    t_wdata    = t_rdata;
                    j_next     = j_reg - 1'b1;
                    state_next = S_SORT_RJ;
                end
                else
                begin
                    t_wdata    = v_reg;
                    i_next     = i_reg + 1'b1;
                    state_next = (i_reg + 1'b1 >= cnt_reg) ? S_REF_RD : S_SORT_RI;
                end
            end

            // Ratios reference/sample per row; row 0 is one.
            S_REF_RD:
            begin
                t_raddr    = '0;
                state_next = S_REF_W;
            end
            S_REF_W:
            begin
                ref_next   = t_rdata;
                r_we       = 1'b1;
                r_waddr    = '0;
                i_next     = CW'(1);
                state_next = S_CAL_RD;
            end
            S_CAL_RD:
            begin
                if (i_reg >= cnt_reg)
                begin
                    cal_next   = 1'b1;
                    stat_next  = STAT_LOADED;
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    t_raddr    = i_reg;
                    state_next = S_CAL_S;
                end
            end
            S_CAL_S:
            begin
                v_next     = t_rdata;
                ch_next    = 2'd0;
                state_next = S_CAL_DIV;
            end
            S_CAL_DIV:
            begin
                dreq.start = 1'b1;
                state_next = S_CAL_WAIT;
            end
            S_CAL_WAIT:
            begin
                if (drsp.done)
                begin
                    unique case (ch_reg)
                        2'd0:
                        begin
                            q0_next    = drsp.quotient;
                            ch_next    = 2'd1;
                            state_next = S_CAL_DIV;
                        end
                        2'd1:
                        begin
                            q1_next    = drsp.quotient;
                            ch_next    = 2'd2;
                            state_next = S_CAL_DIV;
                        end
                        default:
                        begin
                            r_we       = 1'b1;
                            r_waddr    = i_reg;
                            r_wdata    = '{blue: drsp.quotient, green: q1_reg, red: q0_reg};
                            i_next     = i_reg + 1'b1;
                            state_next = S_CAL_RD;
                        end
                    endcase
                end
            end

            // Search downward for the highest row brighter than the measurement.
            S_SRCH_RD:
            begin
                if (i_reg == '0)
                begin
                    state_next = S_RAT_RD;
                end
                else
                begin
                    t_raddr    = i_reg;
                    state_next = S_SRCH_CMP;
                end
            end
            S_SRCH_CMP:
            begin
                if (t_rdata.clear > req_reg.clear)
                begin
                    state_next = S_RAT_RD;
                end
                else
                begin
                    i_next     = i_reg - 1'b1;
                    state_next = S_SRCH_RD;
                end
            end
            S_RAT_RD:
            begin
                r_raddr    = i_reg;
                state_next = S_RAT_W;
            end
            S_RAT_W:
            begin
                rat_next   = r_rdata;
                ch_next    = 2'd0;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                p_next     = (prod[47:32] != '0) ? '1 : prod[31:16];
                state_next = S_CORR;
            end
            S_CORR, S_CORR_WAIT:
            begin
                if (state_reg == S_CORR && ref_ch != '0)
                begin
                    dreq.start    = 1'b1;
                    dreq.dividend = {8'd0, p_reg, 8'd0} - {16'd0, p_reg};
                    dreq.divisor  = ref_ch;
                    state_next    = S_CORR_WAIT;
                end
                else if (state_reg == S_CORR || drsp.done)
                begin
                    if (state_reg == S_CORR)
                    begin
                        res = (p_reg != '0) ? 8'hFF : 8'h00;
                    end
                    else
                    begin
                        res = (drsp.quotient[31:8] != '0) ? 8'hFF : drsp.quotient[7:0];
                    end
                    unique case (ch_reg)
                        2'd0:
                        begin
                            r_next     = res;
                            ch_next    = 2'd1;
                            state_next = S_MUL;
                        end
                        2'd1:
                        begin
                            g_next     = res;
                            ch_next    = 2'd2;
                            state_next = S_MUL;
                        end
                        default:
                        begin
                            b_next     = res;
                            stat_next  = STAT_OK;
                            ov_next    = 1'b1;
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            cal_reg   <= 1'b0;
            ov_reg    <= 1'b0;
            i_reg     <= '0;
            j_reg     <= '0;
            ch_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            cal_reg   <= cal_next;
            ov_reg    <= ov_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            ch_reg    <= ch_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        v_reg    <= v_next;
        ref_reg  <= ref_next;
        q0_reg   <= q0_next;
        q1_reg   <= q1_next;
        rat_reg  <= rat_next;
        p_reg    <= p_next;
        r_reg    <= r_next;
        g_reg    <= g_next;
        b_reg    <= b_next;
        stat_reg <= stat_next;
    end

    assign din.ready      = (state_reg == S_IDLE) && !ov_reg;
    assign dout.valid     = ov_reg;
    assign dout.out_red   = r_reg;
    assign dout.out_green = g_reg;
    assign dout.out_blue  = b_reg;
    assign dout.status    = stat_reg;
endmodule
`default_nettype wire

FILE: hw/rtl/ccc_checker.sv
// Port-level checks for the color calibration and correction top level.
`default_nettype none
module ccc_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] out_red,
    input wire logic [7:0] out_green,
    input wire logic [7:0] out_blue,
    input wire logic [1:0] status
);
    import ccc_pkg::*;

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status))
        else $error("result dropped while stalled");

    a_zero_on_reject: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STAT_OK |-> out_red == '0 && out_green == '0 && out_blue == '0)
        else $error("nonzero color with non-converted status");

    a_no_take_while_pending: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("item taken while result pending");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready right after taking an item");
endmodule

bind color_calibration_correct_top ccc_checker u_ccc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (din.valid),
    .in_ready  (din.ready),
    .out_valid (dout.valid),
    .out_ready (dout.ready),
    .out_red   (dout.out_red),
    .out_green (dout.out_green),
    .out_blue  (dout.out_blue),
    .status    (dout.status)
);
`default_nettype wire
